FILE: hdl/ifb_pkg.sv
package ifb_pkg;

    localparam int FRAME_PIXELS = 131072;
    localparam int PIXEL_BITS   = 32;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int NUM_STORES   = 3;

    localparam logic [31:0] PIX_MASK       = 32'((64'd1 << PIXEL_BITS) - 64'd1);
    localparam logic [31:0] COLOR_MASK_RST = 32'h00fe_fefe;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [1:0]        store_idx_t;
    typedef logic [1:0]        phase_t;

    localparam store_idx_t STORE_A = 2'd0;
    localparam store_idx_t STORE_B = 2'd1;
    localparam store_idx_t STORE_C = 2'd2;

    localparam phase_t PHASE_0 = 2'd0;
    localparam phase_t PHASE_1 = 2'd1;
    localparam phase_t PHASE_2 = 2'd2;

    typedef enum logic [0:0] {
        REG_BLEND_MODE = 1'b0,
        REG_COLOR_MASK = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic [16:0] pixel_addr;
        logic        frame_end;
    } pix_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        frame_done;
    } res_t;

    // The address wraps at the store depth.
    function automatic addr_t addr_of(input logic [16:0] a);
        logic [31:0] wide;
        wide = 32'(a);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic store_idx_t newest_of(input phase_t ph);
        store_idx_t r;
        case (ph)
            PHASE_1: r = STORE_C;
            PHASE_2: r = STORE_B;
            default: r = STORE_A;
        endcase
        return r;
    endfunction

    function automatic store_idx_t middle_of(input phase_t ph);
        store_idx_t r;
        case (ph)
            PHASE_1: r = STORE_A;
            PHASE_2: r = STORE_C;
            default: r = STORE_B;
        endcase
        return r;
    endfunction

    function automatic store_idx_t oldest_of(input phase_t ph);
        store_idx_t r;
        case (ph)
            PHASE_1: r = STORE_B;
            PHASE_2: r = STORE_A;
            default: r = STORE_C;
        endcase
        return r;
    endfunction

    function automatic phase_t phase_step(input phase_t ph);
        phase_t r;
        case (ph)
            PHASE_0: r = PHASE_1;
            PHASE_1: r = PHASE_2;
            default: r = PHASE_0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/ifb_ram.sv
module ifb_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read in the same cycle as a write to that address returns the old word.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/interframe_flicker_blend_core.sv
// Interframe flicker blend core.
// Pixels arrive on the pix channel (valid/stall) with a frame address and a
// last-pixel mark; one filtered pixel leaves on the res channel per input.
// Registers are written through the cfg channel (valid/ready, always ready):
// index 0 selects smart flicker blend or motion blur, index 1 holds the
// color mask. Write them only while no pixel is in flight.
// Three frame stores live in single-port-read RAMs. A pixel is read from all
// three on acceptance, forwarded against writes still in the pipe, compared
// and averaged, and written back from stage 2.
// An accepted pixel passes stages 1, 2 and 3 to the output queue, and the
// core takes one pixel every cycle while pix_stall is low.
// After reset the core sweeps all three stores to zero, one address a cycle,
// over all FRAME_PIXELS (131072) addresses; pix_stall stays high during the sweep.
// When the receiver stalls, results collect in a two-entry output queue;
// once it is full the whole pipeline freezes and pix_stall rises, so no
// transfer is lost or repeated.
module interframe_flicker_blend_core
    import ifb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    output logic     pix_stall,
    input  pix_t     pix,
    output logic     res_valid,
    input  logic     res_stall,
    output res_t     res,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_reg_t cfg_index,
    input  logic [31:0] cfg_data
);

    logic        blend_mode_reg;
    logic [31:0] color_mask_reg;
    phase_t      phase_reg;
    logic        clearing_reg;
    addr_t       clr_cnt_reg;

    logic advance;
    logic accept;

    // Stage 1: RAM read data arrives.
    logic        s1_valid_reg;
    logic [31:0] s1_cur_reg;
    addr_t       s1_addr_reg;
    logic        s1_last_reg;
    phase_t      s1_phase_reg;
    store_idx_t  s1_wst_reg;

    // Stage 2: forwarded frame values.
    logic        s2_valid_reg;
    logic [31:0] s2_cur_reg;
    logic [31:0] s2_n_reg;
    logic [31:0] s2_m_reg;
    logic [31:0] s2_o_reg;
    addr_t       s2_addr_reg;
    logic        s2_last_reg;
    store_idx_t  s2_wst_reg;

    // Stage 3: blend decision and average.
    logic        s3_valid_reg;
    logic        s3_blend_reg;
    logic [31:0] s3_sum_reg;
    logic [31:0] s3_cur_reg;
    addr_t       s3_addr_reg;
    logic        s3_last_reg;
    store_idx_t  s3_wst_reg;

    // Output queue.
    logic out_valid_reg;
    res_t out_data_reg;
    logic skid_valid_reg;
    res_t skid_data_reg;

    logic [31:0] ram_rdata [NUM_STORES];
    logic [31:0] fwd       [NUM_STORES];
    logic        ram_we    [NUM_STORES];
    addr_t       ram_waddr;
    logic [31:0] ram_wdata;
    addr_t       in_addr;

    logic [31:0] cur_in;
    store_idx_t  in_wst;
    logic [31:0] mask;
    logic        flick;
    logic [31:0] sum;
    logic        push;
    logic        pop;
    res_t        push_data;

    assign cfg_ready = 1'b1;

    // The pipeline moves in lockstep and freezes only when the queue is full.
    assign advance   = !skid_valid_reg;
    assign pix_stall = !advance || clearing_reg;
    assign accept    = pix_valid && !pix_stall;

    assign in_addr = addr_of(pix.pixel_addr);
    assign cur_in  = pix.pixel_in & PIX_MASK;
    assign in_wst  = blend_mode_reg ? newest_of(phase_reg) : oldest_of(phase_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= 1'b0;
            color_mask_reg <= COLOR_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLEND_MODE: blend_mode_reg <= cfg_data[0];
                REG_COLOR_MASK: color_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
        end
        else if (accept && !blend_mode_reg && pix.frame_end)
        begin
            phase_reg <= phase_step(phase_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == addr_t'(FRAME_PIXELS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + addr_t'(1);
        end
    end

    // Write port: zero sweep after reset, else the item leaving stage 2.
    assign ram_waddr = clearing_reg ? clr_cnt_reg : s2_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : s2_cur_reg;

    for (genvar g = 0; g < NUM_STORES; g++)
    begin : g_store
        assign ram_we[g] = clearing_reg ||
                           (advance && s2_valid_reg && (s2_wst_reg == store_idx_t'(g)));

        ifb_ram #(
            .DATA_W (32),
            .DEPTH  (FRAME_PIXELS)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (advance),
            .raddr (in_addr),
            .rdata (ram_rdata[g])
        );
    end

    // Stage 0 -> 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cur_reg   <= cur_in;
            s1_addr_reg  <= in_addr;
            s1_last_reg  <= pix.frame_end;
            s1_phase_reg <= phase_reg;
            s1_wst_reg   <= in_wst;
        end
    end

    // The RAM read missed the write of the item now in stage 3 (same edge)
    // and the pending write of the item in stage 2; the newer one wins.
    always_comb
    begin
        for (int p = 0; p < NUM_STORES; p++)
        begin
            fwd[p] = ram_rdata[p];
            if (s3_valid_reg && (s3_wst_reg == store_idx_t'(p)) &&
                (s3_addr_reg == s1_addr_reg))
            begin
                fwd[p] = s3_cur_reg;
            end
            if (s2_valid_reg && (s2_wst_reg == store_idx_t'(p)) &&
                (s2_addr_reg == s1_addr_reg))
            begin
                fwd[p] = s2_cur_reg;
            end
        end
    end

    // Stage 1 -> 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_cur_reg  <= s1_cur_reg;
            s2_n_reg    <= fwd[newest_of(s1_phase_reg)];
            s2_m_reg    <= fwd[middle_of(s1_phase_reg)];
            s2_o_reg    <= fwd[oldest_of(s1_phase_reg)];
            s2_addr_reg <= s1_addr_reg;
            s2_last_reg <= s1_last_reg;
            s2_wst_reg  <= s1_wst_reg;
        end
    end

    assign mask  = color_mask_reg & PIX_MASK;
    assign flick = (s2_n_reg != s2_m_reg) && (s2_o_reg != s2_cur_reg) &&
                   ((s2_cur_reg == s2_m_reg) || (s2_n_reg == s2_o_reg));
    assign sum   = (((s2_cur_reg & mask) >> 1) + ((s2_n_reg & mask) >> 1)) & PIX_MASK;

    // Stage 2 -> 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_blend_reg <= blend_mode_reg || flick;
            s3_sum_reg   <= sum;
            s3_cur_reg   <= s2_cur_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_last_reg  <= s2_last_reg;
            s3_wst_reg   <= s2_wst_reg;
        end
    end

    // Stage 3 -> output queue
    assign push                 = advance && s3_valid_reg;
    assign pop                  = out_valid_reg && !res_stall;
    assign push_data.pixel_out  = s3_blend_reg ? s3_sum_reg : s3_cur_reg;
    assign push_data.frame_done = s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push && out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end

            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= skid_valid_reg || push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        if (!skid_valid_reg && push && out_valid_reg && !pop)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_data_reg;

endmodule

FILE: verif/tb_interframe_flicker_blend_core.sv
module tb_interframe_flicker_blend_core;
    import ifb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The longest quiet stretch of a correct run is the store sweep after reset.
    localparam int unsigned WATCHDOG_LIMIT = 4 * FRAME_PIXELS + 10000;
    localparam int unsigned DRAIN_CYCLES   = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    pix_t        pix       = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_BLEND_MODE;
    logic [31:0] cfg_data  = '0;

    interframe_flicker_blend_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow of the block: three frame stores, the rotation and the registers.
    bit [31:0]   frame_mem [3][FRAME_PIXELS];
    int unsigned rot_phase = 0;
    logic        mode_q    = 1'b0;
    logic [31:0] mask_q    = COLOR_MASK_RST;

    pix_t        pix_pending [$];
    res_t        expected_px [$];
    res_t        want_res;
    int unsigned pix_idle_pct  = 29;
    int unsigned res_stall_pct = 29;
    int unsigned errors        = 0;
    int unsigned quiet_cycles  = 0;

    function automatic logic [31:0] halve_add(logic [31:0] x, logic [31:0] y);
        logic [31:0] mk;
        mk = mask_q & PIX_MASK;
        return (((x & mk) >> 1) + ((y & mk) >> 1)) & PIX_MASK;
    endfunction

    function automatic res_t blend_predict(pix_t p);
        logic [31:0] cur, n, m, o, outp;
        int unsigned ad, ni, mi, oi;
        bit          flick;
        res_t        r;
        cur = p.pixel_in & PIX_MASK;
        ad  = int'(p.pixel_addr) % FRAME_PIXELS;
        ni  = (3 - rot_phase) % 3;
        mi  = (ni + 1) % 3;
        oi  = (ni + 2) % 3;
        n   = frame_mem[ni][ad];
        if (mode_q)
        begin
            outp = halve_add(cur, n);
            frame_mem[ni][ad] = cur;
        end
        else
        begin
            m     = frame_mem[mi][ad];
            o     = frame_mem[oi][ad];
            flick = (n != m) && (o != cur) && ((cur == m) || (n == o));
            outp  = flick ? halve_add(cur, n) : cur;
            frame_mem[oi][ad] = cur;
            if (p.frame_end)
                rot_phase = (rot_phase + 1) % 3;
        end
        r.pixel_out  = outp & PIX_MASK;
        r.frame_done = p.frame_end;
        return r;
    endfunction

    // Driver: predicts each accepted pixel and presents the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                expected_px.push_back(blend_predict(pix));
            if (!pix_valid || !pix_stall)
            begin
                if (pix_pending.size() > 0 && $urandom_range(99) >= pix_idle_pct)
                begin
                    pix       <= pix_pending.pop_front();
                    pix_valid <= 1'b1;
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_px.size() == 0)
                begin
                    $error("unexpected result: pixel_out %h frame_done %b",
                           res.pixel_out, res.frame_done);
                    errors++;
                end
                else
                begin
                    want_res = expected_px.pop_front();
                    if (res.pixel_out !== want_res.pixel_out)
                    begin
                        $error("pixel_out expected %h actual %h",
                               want_res.pixel_out, res.pixel_out);
                        errors++;
                    end
                    if (res.frame_done !== want_res.frame_done)
                    begin
                        $error("frame_done expected %b actual %b",
                               want_res.frame_done, res.frame_done);
                        errors++;
                    end
                end
            end
            res_stall <= ($urandom_range(99) < res_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_interframe_flicker_blend_core: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_pixel(logic [31:0] v, logic [16:0] a, logic fe);
        pix_t p;
        p.pixel_in   = v;
        p.pixel_addr = a;
        p.frame_end  = fe;
        pix_pending.push_back(p);
    endtask

    // Both registers in one burst; valid stays high between the two transfers.
    task automatic set_mode(logic mode, logic [31:0] mask);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BLEND_MODE;
        cfg_data  <= {31'd0, mode};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_COLOR_MASK;
        cfg_data  <= mask;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_q = mode;
        mask_q = mask;
    endtask

    // The falling edge sees the driver's and the monitor's updates settled.
    task automatic drain;
        while (pix_pending.size() > 0 || pix_valid || expected_px.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Scenes of a few addresses whose pixels mostly alternate between two
    // values frame after frame, so the flicker test sees real history.
    // A few frames are broken: stray addresses, missing or early frame ends.
    task automatic queue_scenes(int unsigned n_items);
        logic [16:0] addrs [8];
        logic [31:0] pal_a [8];
        logic [31:0] pal_b [8];
        int unsigned left, width, frames, pick;
        logic [31:0] v;
        logic [16:0] a;
        logic        fe;
        bit          broken;
        left = n_items;
        while (left > 0)
        begin
            width = $urandom_range(1, 8);
            for (int k = 0; k < width; k++)
            begin
                addrs[k] = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                                    : 17'($urandom_range(63));
                pal_a[k] = $urandom;
                pal_b[k] = ($urandom_range(3) == 0) ? pal_a[k] ^ (32'd1 << $urandom_range(31))
                                                    : $urandom;
            end
            frames = $urandom_range(3, 9);
            for (int f = 0; f < frames && left > 0; f++)
            begin
                broken = ($urandom_range(9) == 0);
                for (int k = 0; k < width && left > 0; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        v = f[0] ? pal_b[k] : pal_a[k];
                    else if (pick < 85)
                        v = pick[0] ? pal_a[k] : pal_b[k];
                    else
                        v = $urandom;
                    a = addrs[k];
                    if (broken && $urandom_range(3) == 0)
                        a = 17'($urandom_range(131071));
                    if (k == width - 1)
                        fe = !(broken && $urandom_range(1) == 1);
                    else
                        fe = broken && $urandom_range(4) == 0;
                    push_pixel(v, a, fe);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: alternating extremes at the lowest address, two alternating values
        // at the highest, enough frames for the flicker rule to trigger, reset settings.
        for (int f = 1; f <= 5; f++)
        begin
            push_pixel(f[0] ? 32'hffff_ffff : 32'h0000_0000, 17'd0, 1'b0);
            push_pixel(f[0] ? 32'h1234_5678 : 32'hedcb_a987, 17'd131071, 1'b1);
        end
        drain();

        // Motion blur with a mask that keeps the low bits, so channel carries
        // spill over; a frame end here must not rotate.
        set_mode(1'b1, 32'hffff_ffff);
        push_pixel(32'hffff_ffff, 17'd0, 1'b0);
        push_pixel(32'h0101_0101, 17'd0, 1'b1);
        push_pixel(32'h0101_0101, 17'd0, 1'b0);
        push_pixel(32'h0000_0000, 17'd131071, 1'b1);
        drain();

        set_mode(1'b1, 32'h0000_0000);
        push_pixel(32'hffff_ffff, 17'd131071, 1'b0);
        push_pixel(32'ha5a5_a5a5, 17'd0, 1'b1);
        drain();

        // Random phases.
        set_mode(1'b0, COLOR_MASK_RST);
        queue_scenes(300);
        drain();

        // A long stretch with neither side idling.
        pix_idle_pct  = 0;
        res_stall_pct = 0;
        set_mode(1'b0, 32'hffff_ffff);
        queue_scenes(200);
        drain();
        pix_idle_pct  = 29;
        res_stall_pct = 29;

        set_mode(1'b1, COLOR_MASK_RST);
        queue_scenes(150);
        drain();

        set_mode(1'b0, $urandom);
        queue_scenes(150);
        drain();

        set_mode(1'b1, 32'h0000_0000);
        queue_scenes(100);
        drain();

        set_mode(1'b0, 32'h7f7f_7f7f);
        queue_scenes(200);
        drain();

        if (expected_px.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_px.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_interframe_flicker_blend_core: PASS");
        else
            $display("tb_interframe_flicker_blend_core: FAIL");
        $finish;
    end

endmodule

FILE: interframe_flicker_blend_core.f
hdl/ifb_pkg.sv
hdl/ifb_ram.sv
hdl/interframe_flicker_blend_core.sv
verif/tb_interframe_flicker_blend_core.sv
